[hw/rtl/rtmws_pkg.sv]
`timescale 1ns / 1ps

package rtmws_pkg;

	// Frame geometry limits used by the window test
	localparam int unsigned MAX_COLUMNS = 1024;
	localparam int unsigned MAX_ROWS    = 1024;

	localparam int NumCh    = 3;
	localparam int ChanW    = 8;
	localparam int PosW     = 10;
	localparam int BoundW   = 11;
	localparam int LimW     = 16;
	localparam int SumW     = 28;
	localparam int TallyW   = 21;
	localparam int RegIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int GeoW     = 13;

	localparam logic [ChanW-1:0]  CHANNEL_TOP  = '1;
	localparam logic [BoundW-1:0] WIN_HIGH_RST = BoundW'(1024);
	localparam logic [LimW-1:0]   LIMITS_RST   = 16'hFF00;
	localparam logic [GeoW-1:0]   COL_LIMIT    = GeoW'(MAX_COLUMNS);
	localparam logic [GeoW-1:0]   ROW_LIMIT    = GeoW'(MAX_ROWS);

	typedef enum logic [RegIdxW-1:0] {
		REG_WIN_X_LOW,
		REG_WIN_X_HIGH,
		REG_WIN_Y_LOW,
		REG_WIN_Y_HIGH,
		REG_RED_LIMITS,
		REG_GREEN_LIMITS,
		REG_BLUE_LIMITS
	} reg_index_t;

	typedef struct packed {
		logic [PosW-1:0]              x_low;
		logic [BoundW-1:0]            x_high;
		logic [PosW-1:0]              y_low;
		logic [BoundW-1:0]            y_high;
		logic [NumCh-1:0][LimW-1:0]   limits;  // index 0 red, 1 green, 2 blue
	} cfg_t;

	typedef struct packed {
		logic [NumCh-1:0][ChanW-1:0]  color;
		logic [PosW-1:0]              column;
		logic [PosW-1:0]              row;
		logic                         frame_end;
	} pixel_t;

	typedef struct packed {
		logic match;
		logic in_window;
	} class_t;

	typedef struct packed {
		logic [NumCh-1:0][SumW-1:0]   sum;
		logic [TallyW-1:0]            tally;
		logic [NumCh-1:0][ChanW-1:0]  minv;
		logic [NumCh-1:0][ChanW-1:0]  maxv;
	} stats_t;

	typedef struct packed {
		logic   is_match;
		logic   stats_valid;
		stats_t stats;
	} result_t;

endpackage

[hw/rtl/rtmws_if.sv]
`timescale 1ns / 1ps

interface rtmws_pixel_if;
	import rtmws_pkg::*;

	logic              valid;
	logic              ready;
	logic [ChanW-1:0]  red;
	logic [ChanW-1:0]  green;
	logic [ChanW-1:0]  blue;
	logic [PosW-1:0]   column;
	logic [PosW-1:0]   row;
	logic              frame_end;

	modport source (output valid, red, green, blue, column, row, frame_end, input ready);
	modport sink   (input valid, red, green, blue, column, row, frame_end, output ready);
endinterface

interface rtmws_result_if;
	import rtmws_pkg::*;

	logic               valid;
	logic               ready;
	logic               is_match;
	logic               stats_valid;
	logic [SumW-1:0]    sum_red;
	logic [SumW-1:0]    sum_green;
	logic [SumW-1:0]    sum_blue;
	logic [TallyW-1:0]  window_pixels;
	logic [ChanW-1:0]   min_red;
	logic [ChanW-1:0]   max_red;
	logic [ChanW-1:0]   min_green;
	logic [ChanW-1:0]   max_green;
	logic [ChanW-1:0]   min_blue;
	logic [ChanW-1:0]   max_blue;

	modport source (output valid, is_match, stats_valid, sum_red, sum_green, sum_blue,
		window_pixels, min_red, max_red, min_green, max_green, min_blue, max_blue,
		input ready);
	modport sink   (input valid, is_match, stats_valid, sum_red, sum_green, sum_blue,
		window_pixels, min_red, max_red, min_green, max_green, min_blue, max_blue,
		output ready);
endinterface

[hw/rtl/rtmws_cfg_regs.sv]
`timescale 1ns / 1ps

module rtmws_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              write_enable,
	input  logic [rtmws_pkg::RegIdxW-1:0]     reg_index,
	input  logic [rtmws_pkg::CfgDataW-1:0]    write_data,
	output rtmws_pkg::cfg_t                   cfg
);
	import rtmws_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low     <= '0;
			cfg_q.x_high    <= WIN_HIGH_RST;
			cfg_q.y_low     <= '0;
			cfg_q.y_high    <= WIN_HIGH_RST;
			cfg_q.limits[0] <= LIMITS_RST;
			cfg_q.limits[1] <= LIMITS_RST;
			cfg_q.limits[2] <= LIMITS_RST;
		end else if (write_enable) begin
			unique case (reg_index_t'(reg_index))
				REG_WIN_X_LOW:    cfg_q.x_low     <= write_data[PosW-1:0];
				REG_WIN_X_HIGH:   cfg_q.x_high    <= write_data[BoundW-1:0];
				REG_WIN_Y_LOW:    cfg_q.y_low     <= write_data[PosW-1:0];
				REG_WIN_Y_HIGH:   cfg_q.y_high    <= write_data[BoundW-1:0];
				REG_RED_LIMITS:   cfg_q.limits[0] <= write_data[LimW-1:0];
				REG_GREEN_LIMITS: cfg_q.limits[1] <= write_data[LimW-1:0];
				REG_BLUE_LIMITS:  cfg_q.limits[2] <= write_data[LimW-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[hw/rtl/rtmws_classify.sv]
`timescale 1ns / 1ps

module rtmws_classify (
	input  rtmws_pkg::cfg_t    cfg,
	input  rtmws_pkg::pixel_t  pix,
	output rtmws_pkg::class_t  cls
);
	import rtmws_pkg::*;

	logic [NumCh-1:0] chan_ok;
	logic             col_ok;
	logic             row_ok;

	// exclusive bounds: low byte below, high byte above
	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			chan_ok[c] = (pix.color[c] > cfg.limits[c][ChanW-1:0]) &&
				(pix.color[c] < cfg.limits[c][LimW-1:ChanW]);
		end
	end

	assign col_ok = (pix.column >= cfg.x_low) && ({1'b0, pix.column} < cfg.x_high) &&
		({{(GeoW-PosW){1'b0}}, pix.column} < COL_LIMIT);
	assign row_ok = (pix.row >= cfg.y_low) && ({1'b0, pix.row} < cfg.y_high) &&
		({{(GeoW-PosW){1'b0}}, pix.row} < ROW_LIMIT);

	assign cls.match     = &chan_ok;
	assign cls.in_window = col_ok && row_ok;
endmodule

[hw/rtl/rtmws_stats.sv]
`timescale 1ns / 1ps

module rtmws_stats (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rtmws_pkg::pixel_t  pix,
	input  rtmws_pkg::class_t  cls,
	output rtmws_pkg::stats_t  report
);
	import rtmws_pkg::*;

	stats_t acc_q;
	stats_t acc_upd;
	logic [SumW:0] sum_ext [NumCh];

	// saturating sums, independent min and max per channel
	always_comb begin
		acc_upd = acc_q;
		for (int c = 0; c < NumCh; c++) begin
			sum_ext[c] = {1'b0, acc_q.sum[c]} + (SumW+1)'(pix.color[c]);
			if (cls.in_window) begin
				acc_upd.sum[c] = sum_ext[c][SumW] ? '1 : sum_ext[c][SumW-1:0];
				if (pix.color[c] < acc_q.minv[c]) begin
					acc_upd.minv[c] = pix.color[c];
				end
				if (pix.color[c] > acc_q.maxv[c]) begin
					acc_upd.maxv[c] = pix.color[c];
				end
			end
		end
		if (cls.in_window && (acc_q.tally != '1)) begin
			acc_upd.tally = acc_q.tally + TallyW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q.sum   <= '0;
			acc_q.tally <= '0;
			acc_q.minv  <= {NumCh{CHANNEL_TOP}};
			acc_q.maxv  <= '0;
		end else if (step) begin
			if (pix.frame_end) begin
				acc_q.sum   <= '0;
				acc_q.tally <= '0;
				acc_q.minv  <= {NumCh{CHANNEL_TOP}};
				acc_q.maxv  <= '0;
			end else begin
				acc_q <= acc_upd;
			end
		end
	end

	assign report = pix.frame_end ? acc_upd : '0;
endmodule

[hw/rtl/rgb_threshold_mask_with_window_stats_core.sv]
`timescale 1ns / 1ps

// Channel   Role    Beat payload
// pixel     sink    red, green, blue, column, row, frame_end
// result    source  is_match, stats_valid, sums, window_pixels, min/max per channel
// write     input   write_enable, reg_index, write_data (no read-back)
//
// One beat per clock sustained while result.ready stays high; a pixel passes through the
// input register, then the result register, before its result is valid.
// The statistics accumulators update as a pixel moves from the input register to the
// result register; all compare, add and min/max logic sits in that single stage.
// arst_n resets the valid flags, the configuration and the accumulators at once.
// A stalled result holds in place; the input register still fills, after which pixel.ready
// drops until the result is taken.

module rgb_threshold_mask_with_window_stats_core (
	input  logic                              clk,
	input  logic                              arst_n,
	rtmws_pixel_if.sink                       pixel,
	rtmws_result_if.source                    result,
	input  logic                              write_enable,
	input  logic [rtmws_pkg::RegIdxW-1:0]     reg_index,
	input  logic [rtmws_pkg::CfgDataW-1:0]    write_data
);
	import rtmws_pkg::*;

	cfg_t    cfg;
	pixel_t  pix_in;
	pixel_t  pix_s1;
	logic    valid_s1;
	class_t  cls;
	stats_t  report;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    ready_s1;
	logic    step;

	rtmws_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	// pack the incoming beat
	assign pix_in.color[0]  = pixel.red;
	assign pix_in.color[1]  = pixel.green;
	assign pix_in.color[2]  = pixel.blue;
	assign pix_in.column    = pixel.column;
	assign pix_in.row       = pixel.row;
	assign pix_in.frame_end = pixel.frame_end;

	// result register frees up when empty or being taken; input register follows
	assign adv_s2      = !valid_s2 || result.ready;
	assign ready_s1    = !valid_s1 || adv_s2;
	assign pixel.ready = ready_s1;
	assign step        = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pixel.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && ready_s1) begin
			pix_s1 <= pix_in;
		end
		if (step) begin
			res_s2.is_match    <= cls.match;
			res_s2.stats_valid <= pix_s1.frame_end;
			res_s2.stats       <= report;
		end
	end

	rtmws_classify u_classify (
		.cfg (cfg),
		.pix (pix_s1),
		.cls (cls)
	);

	// accumulators advance only when the pixel actually moves into the result register
	rtmws_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pix    (pix_s1),
		.cls    (cls),
		.report (report)
	);

	assign result.valid         = valid_s2;
	assign result.is_match      = res_s2.is_match;
	assign result.stats_valid   = res_s2.stats_valid;
	assign result.sum_red       = res_s2.stats.sum[0];
	assign result.sum_green     = res_s2.stats.sum[1];
	assign result.sum_blue      = res_s2.stats.sum[2];
	assign result.window_pixels = res_s2.stats.tally;
	assign result.min_red       = res_s2.stats.minv[0];
	assign result.max_red       = res_s2.stats.maxv[0];
	assign result.min_green     = res_s2.stats.minv[1];
	assign result.max_green     = res_s2.stats.maxv[1];
	assign result.min_blue      = res_s2.stats.minv[2];
	assign result.max_blue      = res_s2.stats.maxv[2];
endmodule

[hw/rtl/rtmws_checker.sv]
`timescale 1ns / 1ps

module rtmws_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          stats_valid,
	input logic [rtmws_pkg::SumW-1:0]    sum_red,
	input logic [rtmws_pkg::SumW-1:0]    sum_green,
	input logic [rtmws_pkg::SumW-1:0]    sum_blue,
	input logic [rtmws_pkg::TallyW-1:0]  window_pixels,
	input logic [rtmws_pkg::ChanW-1:0]   min_red,
	input logic [rtmws_pkg::ChanW-1:0]   max_red,
	input logic [rtmws_pkg::ChanW-1:0]   min_green,
	input logic [rtmws_pkg::ChanW-1:0]   max_green,
	input logic [rtmws_pkg::ChanW-1:0]   min_blue,
	input logic [rtmws_pkg::ChanW-1:0]   max_blue
);
	import rtmws_pkg::*;

	// mid-frame beats carry no statistics
	a_zero_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stats_valid |-> sum_red == '0 && sum_green == '0 && sum_blue == '0 &&
		window_pixels == '0 && min_red == '0 && max_red == '0 && min_green == '0 &&
		max_green == '0 && min_blue == '0 && max_blue == '0)
		else $error("statistics fields nonzero on a mid-frame beat");

	// a frame with no window pixel reports the cleared values
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stats_valid && window_pixels == '0 |-> sum_red == '0 &&
		sum_green == '0 && sum_blue == '0 && min_red == CHANNEL_TOP &&
		min_green == CHANNEL_TOP && min_blue == CHANNEL_TOP && max_red == '0 &&
		max_green == '0 && max_blue == '0)
		else $error("empty window frame did not report cleared statistics");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stats_valid && window_pixels != '0 |-> min_red <= max_red &&
		min_green <= max_green && min_blue <= max_blue)
		else $error("minimum above maximum in a nonempty window");

	// a single window pixel: min, max and sum all equal that pixel
	a_single_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stats_valid && window_pixels == TallyW'(1) |-> min_red == max_red &&
		sum_red == SumW'(min_red) && min_green == max_green &&
		sum_green == SumW'(min_green) && min_blue == max_blue && sum_blue == SumW'(min_blue))
		else $error("single-pixel frame statistics inconsistent");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stats_valid) && $stable(sum_red) &&
		$stable(window_pixels))
		else $error("stalled result beat changed");
endmodule

bind rgb_threshold_mask_with_window_stats_core rtmws_checker u_rtmws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.stats_valid   (result.stats_valid),
	.sum_red       (result.sum_red),
	.sum_green     (result.sum_green),
	.sum_blue      (result.sum_blue),
	.window_pixels (result.window_pixels),
	.min_red       (result.min_red),
	.max_red       (result.max_red),
	.min_green     (result.min_green),
	.max_green     (result.max_green),
	.min_blue      (result.min_blue),
	.max_blue      (result.max_blue)
);

[tb/tb_rgb_threshold_mask_with_window_stats_core.sv]
`timescale 1ns / 1ps

module tb_rgb_threshold_mask_with_window_stats_core;
	import rtmws_pkg::*;

	localparam int CYCLE_LIMIT = 400000;  // watchdog bound; a correct run ends well before it
	localparam int DRAIN_CYCLES = 8;      // input and result registers plus margin
	localparam int HOLD_CYCLES = 50;      // long result stall, fills the pipe
	localparam int SEG_PIXELS = 255;      // minimum pixels per random segment, six segments
	localparam int REPORT_CAP = 100;      // keep the log short on a badly broken build

	logic clk = 1'b0;
	logic arst_n;
	logic write_enable;
	logic [RegIdxW-1:0] reg_index;
	logic [CfgDataW-1:0] write_data;

	rtmws_pixel_if pix_if ();
	rtmws_result_if res_if ();

	rgb_threshold_mask_with_window_stats_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pix_if),
		.result       (res_if),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block: configuration plus the running frame stats.
	// Updated in beat order as pixels are taken, so expectations line up
	// with the result stream one for one.
	// ------------------------------------------------------------------
	cfg_t shadow_cfg;
	stats_t frame_stats;

	pixel_t feed_q[$];        // pixels waiting for the driver
	result_t expect_q[$];     // predicted result beats, oldest first
	int pixels_queued = 0;
	int pix_accepted = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 36;
	int recv_idle_pct = 64;

	// handshake flag from the rising edge, consumed by the driver at the falling edge
	logic pix_taken = 1'b0;
	pixel_t drive_beat;
	pixel_t seen_pixel;
	result_t want;

	// pressure: long receiver hold-offs once enough pixels have gone in
	int hold_marks[2] = '{1100, 1350};
	int hold_idx = 0;
	int hold_left = 0;

	function automatic void clear_frame_stats();
		frame_stats = '0;
		frame_stats.minv = {NumCh{CHANNEL_TOP}};
	endfunction

	// Mask bit, window accumulation and the end-of-frame readout for one pixel.
	function automatic result_t classify_pixel(pixel_t p);
		result_t r;
		logic hit;
		logic in_win;
		logic [SumW:0] acc;
		logic [ChanW-1:0] v;
		int c;
		r = '0;
		hit = 1'b1;
		// each channel must sit strictly between its low byte and high byte
		for (c = 0; c < NumCh; c++) begin
			v = p.color[c];
			if (!(v > shadow_cfg.limits[c][7:0] && v < shadow_cfg.limits[c][15:8]))
				hit = 1'b0;
		end
		// half-open window; an inverted or empty window takes nothing
		in_win = p.column >= shadow_cfg.x_low && {1'b0, p.column} < shadow_cfg.x_high &&
			p.row >= shadow_cfg.y_low && {1'b0, p.row} < shadow_cfg.y_high &&
			int'(p.column) < MAX_COLUMNS && int'(p.row) < MAX_ROWS;
		if (in_win) begin
			for (c = 0; c < NumCh; c++) begin
				v = p.color[c];
				acc = {1'b0, frame_stats.sum[c]} + v;
				frame_stats.sum[c] = acc[SumW] ? {SumW{1'b1}} : acc[SumW-1:0];
				// min and max track separately, a single pixel can set both
				if (v < frame_stats.minv[c])
					frame_stats.minv[c] = v;
				if (v > frame_stats.maxv[c])
					frame_stats.maxv[c] = v;
			end
			if (frame_stats.tally != {TallyW{1'b1}})
				frame_stats.tally = frame_stats.tally + 1'b1;
		end
		r.is_match = hit;
		// stats fields stay zero except on the frame end beat
		if (p.frame_end) begin
			r.stats_valid = 1'b1;
			r.stats = frame_stats;
			clear_frame_stats();
		end
		return r;
	endfunction

	task automatic report(string msg);
		if (fail_count < REPORT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s got %0h expected %0h", name, got, exp_val));
	endtask

	// ------------------------------------------------------------------
	// Rising edge: record pixel beats, predict, and check result beats.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rgb_threshold_mask_with_window_stats_core: FAILED **");
			$finish;
		end else if (arst_n) begin
			pix_taken = pix_if.valid && pix_if.ready;
			if (pix_taken) begin
				seen_pixel.color[0] = pix_if.red;
				seen_pixel.color[1] = pix_if.green;
				seen_pixel.color[2] = pix_if.blue;
				seen_pixel.column = pix_if.column;
				seen_pixel.row = pix_if.row;
				seen_pixel.frame_end = pix_if.frame_end;
				expect_q.push_back(classify_pixel(seen_pixel));
				pix_accepted++;
			end
			if (res_if.valid === 1'b1 && res_if.ready) begin
				if (expect_q.size() == 0) begin
					report("result beat with no pixel pending");
				end else begin
					want = expect_q.pop_front();
					compare_field("is_match", res_if.is_match, want.is_match);
					compare_field("stats_valid", res_if.stats_valid, want.stats_valid);
					compare_field("sum_red", res_if.sum_red, want.stats.sum[0]);
					compare_field("sum_green", res_if.sum_green, want.stats.sum[1]);
					compare_field("sum_blue", res_if.sum_blue, want.stats.sum[2]);
					compare_field("window_pixels", res_if.window_pixels, want.stats.tally);
					compare_field("min_red", res_if.min_red, want.stats.minv[0]);
					compare_field("max_red", res_if.max_red, want.stats.maxv[0]);
					compare_field("min_green", res_if.min_green, want.stats.minv[1]);
					compare_field("max_green", res_if.max_green, want.stats.maxv[1]);
					compare_field("min_blue", res_if.min_blue, want.stats.minv[2]);
					compare_field("max_blue", res_if.max_blue, want.stats.maxv[2]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Pixel driver: falling edge, pulls from feed_q, random gaps.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!pix_if.valid || pix_taken)) begin
			if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_beat = feed_q.pop_front();
				pix_if.valid <= 1'b1;
				pix_if.red <= drive_beat.color[0];
				pix_if.green <= drive_beat.color[1];
				pix_if.blue <= drive_beat.color[2];
				pix_if.column <= drive_beat.column;
				pix_if.row <= drive_beat.row;
				pix_if.frame_end <= drive_beat.frame_end;
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus the long hold-offs. The hold
	// counter lives here; the trigger is the accepted pixel count, which
	// only moves at the rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left == 0 && hold_idx < 2 && pix_accepted >= hold_marks[hold_idx]) begin
				hold_left = HOLD_CYCLES;
				hold_idx++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic write_reg(reg_index_t idx, logic [CfgDataW-1:0] data);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= data;
		case (idx)
			REG_WIN_X_LOW:    shadow_cfg.x_low = data[PosW-1:0];
			REG_WIN_X_HIGH:   shadow_cfg.x_high = data[BoundW-1:0];
			REG_WIN_Y_LOW:    shadow_cfg.y_low = data[PosW-1:0];
			REG_WIN_Y_HIGH:   shadow_cfg.y_high = data[BoundW-1:0];
			REG_RED_LIMITS:   shadow_cfg.limits[0] = data;
			REG_GREEN_LIMITS: shadow_cfg.limits[1] = data;
			REG_BLUE_LIMITS:  shadow_cfg.limits[2] = data;
			default: ;
		endcase
		@(negedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic set_window(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
			logic [15:0] yh);
		write_reg(REG_WIN_X_LOW, xl);
		write_reg(REG_WIN_X_HIGH, xh);
		write_reg(REG_WIN_Y_LOW, yl);
		write_reg(REG_WIN_Y_HIGH, yh);
	endtask

	task automatic set_limits(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		write_reg(REG_RED_LIMITS, r);
		write_reg(REG_GREEN_LIMITS, g);
		write_reg(REG_BLUE_LIMITS, b);
	endtask

	task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [9:0] col, logic [9:0] row, logic fe);
		pixel_t p;
		p.color[0] = r;
		p.color[1] = g;
		p.color[2] = b;
		p.column = col;
		p.row = row;
		p.frame_end = fe;
		feed_q.push_back(p);
		pixels_queued++;
	endtask

	// channel value, biased toward the current bounds and the extremes
	function automatic logic [7:0] pick_level(logic [15:0] lim);
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return lim[7:0];
			3: return lim[7:0] + 8'd1;
			4: return lim[15:8];
			5: return lim[15:8] - 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// position, mostly around the window edges so both sides get hit
	function automatic logic [9:0] pick_pos(logic [9:0] lo, logic [10:0] hi);
		int a;
		int b;
		if ($urandom_range(9) < 6 && hi > {1'b0, lo}) begin
			a = (lo >= 2) ? int'(lo) - 2 : 0;
			b = (int'(hi) + 1 > 1023) ? 1023 : int'(hi) + 1;
			return 10'($urandom_range(b, a));
		end
		return 10'($urandom_range(1023));
	endfunction

	function automatic logic [15:0] random_limits();
		int lo;
		int hi;
		lo = $urandom_range(200);
		hi = lo + $urandom_range(55, 2);
		return {8'(hi), 8'(lo)};
	endfunction

	task automatic random_window();
		int xl;
		int yl;
		xl = $urandom_range(1023);
		yl = $urandom_range(1023);
		set_window(16'(xl), 16'(xl + $urandom_range(40, 1)), 16'(yl),
			16'(yl + $urandom_range(40, 1)));
	endtask

	// Mostly whole frames ending in a frame end beat; a few frames run on
	// into the next one without it, and some are long.
	task automatic queue_frames(int count);
		int n;
		int len;
		int i;
		logic closes;
		n = 0;
		while (n < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1);
			closes = ($urandom_range(9) != 0);
			for (i = 0; i < len; i++)
				queue_pixel(pick_level(shadow_cfg.limits[0]), pick_level(shadow_cfg.limits[1]),
					pick_level(shadow_cfg.limits[2]),
					pick_pos(shadow_cfg.x_low, shadow_cfg.x_high),
					pick_pos(shadow_cfg.y_low, shadow_cfg.y_high),
					(i == len - 1) ? closes : 1'b0);
			n += len;
		end
	endtask

	// Block idle: every pixel taken, every result back, pipe flushed.
	task automatic wait_idle();
		while (pix_accepted != pixels_queued || expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_segment();
		@(posedge clk);
		queue_frames(SEG_PIXELS);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		write_enable = 1'b0;
		reg_index = '0;
		write_data = '0;
		pix_if.valid = 1'b0;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		pix_if.column = '0;
		pix_if.row = '0;
		pix_if.frame_end = 1'b0;
		res_if.ready = 1'b0;

		shadow_cfg.x_low = '0;
		shadow_cfg.x_high = WIN_HIGH_RST;
		shadow_cfg.y_low = '0;
		shadow_cfg.y_high = WIN_HIGH_RST;
		shadow_cfg.limits = {NumCh{LIMITS_RST}};
		clear_frame_stats();

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// phase 1: sender idles lightly, receiver heavily
		send_idle_pct = 36;
		recv_idle_pct = 64;

		// reset config: full window, 1..254 match; channel extremes and corners
		@(posedge clk);
		queue_pixel(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b0);
		queue_pixel(8'd1, 8'd1, 8'd1, 10'd5, 10'd5, 1'b0);
		queue_pixel(8'd254, 8'd254, 8'd254, 10'd6, 10'd7, 1'b0);
		queue_pixel(8'd254, 8'd1, 8'd128, 10'd8, 10'd9, 1'b1);
		wait_idle();

		// small window, red bounds 0x40..0x80, green bounds equal (never matches)
		set_window(16'd10, 16'd20, 16'd10, 16'd20);
		set_limits(16'h8040, 16'h4040, 16'hFF00);
		@(posedge clk);
		queue_pixel(8'd7, 8'd7, 8'd7, 10'd9, 10'd15, 1'b1);       // frame with no window pixel
		queue_pixel(8'h40, 8'd100, 8'd100, 10'd10, 10'd10, 1'b0); // on the lower bound
		queue_pixel(8'h41, 8'h41, 8'd200, 10'd19, 10'd19, 1'b0);  // last window corner
		queue_pixel(8'h80, 8'd3, 8'd50, 10'd20, 10'd19, 1'b0);    // one column past the window
		queue_pixel(8'h7F, 8'd250, 8'd9, 10'd19, 10'd20, 1'b0);   // one row past the window
		queue_pixel(8'd60, 8'd60, 8'd60, 10'd15, 10'd9, 1'b1);
		wait_idle();

		// last column only, high bound written past its range
		set_window(16'd1023, 16'hFFFF, 16'd0, 16'd1024);
		set_limits(16'h8040, 16'hFF00, 16'hFF00);
		@(posedge clk);
		queue_pixel(8'd200, 8'd100, 8'd50, 10'd1023, 10'd0, 1'b0);
		queue_pixel(8'd10, 8'd20, 8'd30, 10'd1022, 10'd1023, 1'b0);
		queue_pixel(8'h41, 8'd128, 8'd254, 10'd1023, 10'd1023, 1'b1);
		wait_idle();

		// empty window, then inverted window
		set_window(16'd500, 16'd500, 16'd0, 16'd1024);
		@(posedge clk);
		queue_pixel(8'd1, 8'd2, 8'd3, 10'd500, 10'd500, 1'b1);
		wait_idle();
		set_window(16'd600, 16'd20, 16'd1023, 16'd0);
		@(posedge clk);
		queue_pixel(8'd4, 8'd5, 8'd6, 10'd600, 10'd1023, 1'b1);
		wait_idle();

		// random part, two segments per idling mix
		set_window(16'd0, 16'd1024, 16'd0, 16'd1024);
		set_limits(16'hFF00, 16'hFF00, 16'hFF00);
		run_segment();

		random_window();
		set_limits(random_limits(), random_limits(), random_limits());
		run_segment();

		// phase 2: swap the idle rates
		send_idle_pct = 64;
		recv_idle_pct = 36;

		// raw 16-bit writes, upper bits dropped by the window registers
		set_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		set_limits(16'($urandom), 16'($urandom), 16'($urandom));
		run_segment();

		random_window();
		set_limits(random_limits(), 16'hFF00, random_limits());
		run_segment();

		// phase 3: no idling; the receiver hold-offs land here
		send_idle_pct = 0;
		recv_idle_pct = 0;

		set_window(16'd0, 16'hFFFF, 16'd0, 16'd1024);
		set_limits(random_limits(), random_limits(), random_limits());
		run_segment();

		// inverted limits on red, zero limits on blue, window high bounds at zero
		set_window(16'd1023, 16'd0, 16'd0, 16'd0);
		set_limits(16'h00FF, 16'hFFFF, 16'h0000);
		run_segment();

		if (fail_count == 0)
			$display("** rgb_threshold_mask_with_window_stats_core: PASSED **");
		else
			$display("** rgb_threshold_mask_with_window_stats_core: FAILED **");
		$finish;
	end

endmodule
